/* rtl/core/command_packet_coalescer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Command packet coalescer - assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef COMMAND_PACKET_COALESCER_UNIT_DEFINES_SVH
`define COMMAND_PACKET_COALESCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// Command packet coalescer - package
// Widths, codes and the command record passed from front end to back end.
// ----------------------------------------------------------------------------
package cpc_pkg;

   localparam int BUFFER_WORDS_DEF = 64;
   localparam int WORD_W           = 32;
   localparam int METHOD_W         = 16;
   localparam int COUNT_W          = 3;
   localparam int MAX_APPEND       = 4;
   localparam int HDR_SHIFT        = 16;
   localparam int QUEUE_DEPTH      = 2;   // power of two
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W      = $clog2(QUEUE_DEPTH + 1);

   // Request command codes on req_command.
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   typedef enum logic [0:0] {
      OP_APPEND,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type                                 op;
      logic [METHOD_W-1:0]                    method;
      logic [COUNT_W-1:0]                     count;   // already clamped to 0..4
      logic [MAX_APPEND-1:0][WORD_W-1:0]      words;
   } cmd_type;

endpackage

/* rtl/core/cpc_front.sv */
// ----------------------------------------------------------------------------
// Command packet coalescer - front end
// Accepts requests, clamps and filters them, and queues commands for the
// back end.
// ----------------------------------------------------------------------------
module cpc_front import cpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [METHOD_W-1:0]  req_method,
   input  logic [COUNT_W-1:0]   req_word_count,
   input  logic [WORD_W-1:0]    req_data_word_0,
   input  logic [WORD_W-1:0]    req_data_word_1,
   input  logic [WORD_W-1:0]    req_data_word_2,
   input  logic [WORD_W-1:0]    req_data_word_3,
   output logic                 head_valid,
   output cmd_type              head,
   input  logic                 pop
);

   cmd_type                  q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0]   level_ff, level_in;
   cmd_type                  cmd;
   logic                     keep;
   logic                     push;

   // Classify: append with method zero is dropped, count clamped to four.
   always_comb begin
      cmd.op     = (req_command == CMD_FLUSH) ? OP_FLUSH : OP_APPEND;
      cmd.method = req_method;
      cmd.count  = (req_word_count > COUNT_W'(MAX_APPEND)) ? COUNT_W'(MAX_APPEND)
                                                           : req_word_count;
      cmd.words  = {req_data_word_3, req_data_word_2, req_data_word_1, req_data_word_0};
      keep       = (req_command == CMD_FLUSH) || (req_method != '0);
   end

   assign req_ready  = (level_ff != QUEUE_LVL_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready && keep;
   assign head_valid = (level_ff != '0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

/* rtl/core/cpc_back.sv */
// ----------------------------------------------------------------------------
// Command packet coalescer - back end
// Holds the word buffer and pending packet, writes appended words one per
// cycle and drains packets (header, then data) through an output register.
// ----------------------------------------------------------------------------
module cpc_back import cpc_pkg::*; #(
   parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  cmd_type              head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_out_word,
   output logic                 rsp_is_header,
   output logic                 rsp_last
);

   localparam int FILL_W = $clog2(BUFFER_WORDS);
   localparam int IDX_W  = $clog2(MAX_APPEND);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_HDR,
      ST_DRAIN
   } state_type;

   logic [WORD_W-1:0]    mem [BUFFER_WORDS];

   state_type            state_ff;
   logic [METHOD_W-1:0]  pend_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [IDX_W-1:0]     widx_ff;
   logic [FILL_W-1:0]    rd_ptr_ff;
   logic                 mq_v_ff;
   logic                 mq_last_ff;
   logic [WORD_W-1:0]    mq_word_ff;
   logic                 out_v_ff;
   logic [WORD_W-1:0]    out_word_ff;
   logic                 out_hdr_ff;
   logic                 out_last_ff;

   logic                 out_free;
   logic                 need_flush;
   logic                 is_flush;
   logic                 last_write;
   logic                 wr_en;
   logic                 hdr_load;
   logic                 load_data;
   logic                 issue;
   logic                 drain_end;
   logic [FILL_W:0]      fill_sum;
   logic [WORD_W-1:0]    hdr_word;

   always_comb begin
      is_flush   = (head.op == OP_FLUSH);
      fill_sum   = (FILL_W+1)'(fill_ff) + (FILL_W+1)'(head.count);
      need_flush = (pend_ff != '0) &&
                   ((pend_ff != head.method) || (fill_sum >= (FILL_W+1)'(BUFFER_WORDS)));
      last_write = ((COUNT_W'(widx_ff) + 1'b1) == head.count);
      out_free   = !out_v_ff || rsp_ready;
      hdr_load   = (state_ff == ST_HDR) && out_free;
      load_data  = (state_ff == ST_DRAIN) && mq_v_ff && out_free;
      issue      = (state_ff == ST_DRAIN) && (rd_ptr_ff != fill_ff) &&
                   (!mq_v_ff || load_data);
      drain_end  = (state_ff == ST_DRAIN) && (rd_ptr_ff == fill_ff) &&
                   (!mq_v_ff || load_data);
      wr_en      = head_valid && !is_flush &&
                   (((state_ff == ST_IDLE) && !need_flush && (head.count != '0)) ||
                    (state_ff == ST_WRITE));
      hdr_word   = (WORD_W'(fill_ff) << HDR_SHIFT) | WORD_W'(pend_ff);

      pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (is_flush) begin
                  pop = (pend_ff == '0);
               end else begin
                  pop = !need_flush && (head.count <= COUNT_W'(1));
               end
            end
         end
         ST_WRITE: pop = last_write;
         ST_HDR:   pop = hdr_load && (fill_ff == '0) && is_flush;
         ST_DRAIN: pop = drain_end && is_flush;
         default:  pop = 1'b0;
      endcase
   end

   // Word buffer: at most one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff] <= head.words[widx_ff];
      end
      if (issue) begin
         mq_word_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= '0;
         fill_ff    <= '0;
         widx_ff    <= '0;
         rd_ptr_ff  <= '0;
         mq_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         // output register
         if (hdr_load) begin
            out_v_ff    <= 1'b1;
            out_word_ff <= hdr_word;
            out_hdr_ff  <= 1'b1;
            out_last_ff <= (fill_ff == '0);
         end else if (load_data) begin
            out_v_ff    <= 1'b1;
            out_word_ff <= mq_word_ff;
            out_hdr_ff  <= 1'b0;
            out_last_ff <= mq_last_ff;
         end else if (rsp_ready) begin
            out_v_ff    <= 1'b0;
         end

         // read data stage
         if (issue) begin
            mq_v_ff    <= 1'b1;
            mq_last_ff <= ((rd_ptr_ff + 1'b1) == fill_ff);
         end else if (load_data) begin
            mq_v_ff    <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  if (is_flush) begin
                     if (pend_ff != '0) begin
                        state_ff <= ST_HDR;
                     end
                  end else if (need_flush) begin
                     state_ff <= ST_HDR;
                  end else if (head.count == '0) begin
                     pend_ff <= head.method;
                  end else begin
                     fill_ff <= fill_ff + 1'b1;
                     if (head.count == COUNT_W'(1)) begin
                        pend_ff <= head.method;
                     end else begin
                        widx_ff  <= IDX_W'(1);
                        state_ff <= ST_WRITE;
                     end
                  end
               end
            end
            ST_WRITE: begin
               fill_ff <= fill_ff + 1'b1;
               if (last_write) begin
                  pend_ff  <= head.method;
                  widx_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  widx_ff  <= widx_ff + 1'b1;
               end
            end
            ST_HDR: begin
               if (out_free) begin
                  if (fill_ff == '0) begin
                     pend_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     rd_ptr_ff <= '0;
                     state_ff  <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (issue) begin
                  rd_ptr_ff <= rd_ptr_ff + 1'b1;
               end
               if (drain_end) begin
                  pend_ff   <= '0;
                  fill_ff   <= '0;
                  rd_ptr_ff <= '0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_out_word  = out_word_ff;
   assign rsp_is_header = out_hdr_ff;
   assign rsp_last      = out_last_ff;

endmodule

/* rtl/core/command_packet_coalescer_unit.sv */
// ----------------------------------------------------------------------------
// Command packet coalescer - top level
// Batches method/data requests into packets of header plus data words.
//
//   channel   ports     direction   carries
//   request   req_*     in          append (method, 0..4 words) or flush
//   response  rsp_*     out         one packet word: header or data
//
// Flow: the front end takes one request per cycle while its two-entry
// command queue has room. The back end owns the word buffer: an append
// writes its words into it, one buffer write per cycle. A packet drains
// as a dispatch step, the header, then its data words one per cycle
// behind the buffer's registered read while rsp_ready stays high.
// Reset: synchronous, clears the queue, pending method, fill count and
// output valid. The word buffer is not cleared; only written entries
// are ever read.
// Stalls: rsp_ready low holds the output register and pauses the drain;
// the queue keeps accepting until full, then req_ready drops.
// ----------------------------------------------------------------------------
module command_packet_coalescer_unit import cpc_pkg::*; #(
   parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [METHOD_W-1:0]  req_method,
   input  logic [COUNT_W-1:0]   req_word_count,
   input  logic [WORD_W-1:0]    req_data_word_0,
   input  logic [WORD_W-1:0]    req_data_word_1,
   input  logic [WORD_W-1:0]    req_data_word_2,
   input  logic [WORD_W-1:0]    req_data_word_3,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_out_word,
   output logic                 rsp_is_header,
   output logic                 rsp_last
);

   // Queue head handed from front to back; pop retires it.
   logic     head_valid;
   cmd_type  head;
   logic     pop;

   // Front: filters zero-method appends, clamps word count, queues commands.
   cpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_method      (req_method),
      .req_word_count  (req_word_count),
      .req_data_word_0 (req_data_word_0),
      .req_data_word_1 (req_data_word_1),
      .req_data_word_2 (req_data_word_2),
      .req_data_word_3 (req_data_word_3),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop)
   );

   // Back: decides forced flushes (method change or capacity), writes the
   // buffer, and streams packets out.
   cpc_back #(
      .BUFFER_WORDS (BUFFER_WORDS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_word  (rsp_out_word),
      .rsp_is_header (rsp_is_header),
      .rsp_last      (rsp_last)
   );

endmodule

/* rtl/core/cpc_port_checker.sv */
// ----------------------------------------------------------------------------
// Command packet coalescer - port checker
// Concurrent checks on the response port, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_packet_coalescer_unit_defines.svh"

module cpc_port_checker import cpc_pkg::*; #(
   parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [WORD_W-1:0]   rsp_out_word,
   input logic                rsp_is_header,
   input logic                rsp_last
);

   `CPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_word), "rsp dropped or changed while stalled")
   `CPC_ASSERT_NOW(a_hdr_method, clock, reset, rsp_valid && rsp_is_header, rsp_out_word[15:0] != '0, "header with empty method")
   `CPC_ASSERT_NOW(a_hdr_count, clock, reset, rsp_valid && rsp_is_header, rsp_out_word[31:16] < 16'(BUFFER_WORDS), "header count over capacity")
   `CPC_ASSERT_NOW(a_hdr_last, clock, reset, rsp_valid && rsp_is_header, rsp_last == (rsp_out_word[31:16] == '0), "header last mismatch")

endmodule

bind command_packet_coalescer_unit cpc_port_checker #(
   .BUFFER_WORDS (BUFFER_WORDS)
) u_port_checker (.*);
